### design/bra_pkg.sv
package bra_pkg;

  localparam int BIT_W  = 11;
  localparam int BYTE_W = 8;

  localparam logic [BYTE_W-1:0] CFG_RESET = 8'd128;

  localparam logic [2:0] KIND_ALLOC     = 3'd0;
  localparam logic [2:0] KIND_MARK_USED = 3'd1;
  localparam logic [2:0] KIND_MARK_FREE = 3'd2;
  localparam logic [2:0] KIND_FILL_USED = 3'd3;
  localparam logic [2:0] KIND_FILL_FREE = 3'd4;
  localparam logic [2:0] KIND_TEST      = 3'd5;

  typedef struct packed {
    logic [2:0]  kind;
    logic [9:0]  start_bit;
    logic [10:0] run_length;
    logic        search_down;
  } item_t;

  typedef struct packed {
    logic        ok;
    logic [9:0]  run_start;
    logic [10:0] run_size;
    logic        bit_value;
    logic [10:0] used_count;
  } res_t;

  typedef struct packed {
    logic [BIT_W-1:0] run;
    logic [BIT_W-1:0] first;
  } scan_state_t;

  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [BYTE_W-1:0] wr_data;
  } mem_ctl_t;

endpackage

### design/bra_map_mem.sv
module bra_map_mem #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/bra_byte_scan.sv
module bra_byte_scan (
  input  logic [7:0]                data,
  input  logic [7:0]                byte_idx,
  input  logic [10:0]               bound,
  input  logic                      down,
  input  logic [10:0]               count,
  input  bra_pkg::scan_state_t      st_in,
  output logic                      found,
  output bra_pkg::scan_state_t      st_out
);

  import bra_pkg::*;

  // Walk the eight bits of one byte in scan order; stop at the bit that closes the run.
  always_comb begin
    scan_state_t st;
    logic        hit;
    logic [2:0]  j;
    logic [10:0] b;
    logic        act;
    st  = st_in;
    hit = 1'b0;
    for (int s = 0; s < 8; s++) begin
      j   = down ? 3'(7 - s) : 3'(s);
      b   = {byte_idx, j};
      act = down ? (b <= bound) : (b >= bound);
      if (act && !hit) begin
        if (data[j]) begin
          st.run = '0;
        end else begin
          if (down || st.run == '0) begin
            st.first = b;
          end
          st.run = st.run + 11'd1;
        end
        if (st.run == count) begin
          hit = 1'b1;
        end
      end
    end
    found  = hit;
    st_out = st;
  end

endmodule

### design/bra_seq.sv
module bra_seq #(
  parameter int MAP_BYTES = 128,
  parameter int AW        = 7
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_take,
  input  bra_pkg::item_t        item,
  input  logic [7:0]            bytes_in_use,
  input  logic                  out_free,
  output logic                  busy,
  output logic                  res_valid,
  output bra_pkg::res_t         res,
  output bra_pkg::mem_ctl_t     mem_ctl,
  output logic [AW-1:0]         rd_addr,
  output logic [AW-1:0]         wr_addr,
  input  logic [7:0]            rd_data
);

  import bra_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_APPLY = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  localparam logic [AW-1:0] CLR_LAST = AW'(MAP_BYTES - 1);

  logic [2:0]        state;
  logic [AW-1:0]     clr_cnt;
  logic [2:0]        kind;
  logic [10:0]       start;
  logic [10:0]       count;
  logic              down;
  logic [7:0]        eff;
  logic [7:0]        idx;
  logic              issuing;
  logic              pend;
  logic [7:0]        pend_idx;
  logic [10:0]       scan_bound;
  scan_state_t       scan_st;
  logic              apply_en;
  logic              set_bits;
  logic [10:0]       lo;
  logic [11:0]       hi_end;
  logic              ok;
  logic              bv;
  logic [10:0]       used;
  logic [9:0]        rs;
  logic [10:0]       rsize;

  logic [7:0]        eff_in;
  logic [10:0]       l_in;
  logic [10:0]       start_in;
  logic [10:0]       dn_bound;
  logic [11:0]       mark_end;
  logic [7:0]        eff_m1;
  logic [7:0]        scan_last;
  logic              scan_hit;
  scan_state_t       scan_st_new;
  logic [7:0]        mask;
  logic [7:0]        new_byte;
  logic [3:0]        pop;

  assign eff_in    = (int'(bytes_in_use) > MAP_BYTES) ? 8'(MAP_BYTES) : bytes_in_use;
  assign l_in      = {eff_in, 3'b000};
  assign start_in  = {1'b0, item.start_bit};
  assign dn_bound  = (start_in < l_in) ? start_in : l_in - 11'd1;
  assign mark_end  = {1'b0, start_in} + {1'b0, item.run_length};
  assign eff_m1    = eff - 8'd1;
  assign scan_last = down ? 8'd0 : eff_m1;

  bra_byte_scan u_scan (
    .data     (rd_data),
    .byte_idx (pend_idx),
    .bound    (scan_bound),
    .down     (down),
    .count    (count),
    .st_in    (scan_st),
    .found    (scan_hit),
    .st_out   (scan_st_new)
  );

  // Range mask for the byte now returning, then the modified byte and its set bits.
  always_comb begin
    logic [10:0] b;
    for (int j = 0; j < 8; j++) begin
      b       = {pend_idx, 3'(j)};
      mask[j] = apply_en && (b >= lo) && ({1'b0, b} < hi_end);
    end
    new_byte = set_bits ? (rd_data | mask) : (rd_data & ~mask);
    pop      = '0;
    for (int j = 0; j < 8; j++) begin
      pop = pop + {3'b000, new_byte[j]};
    end
  end

  always_comb begin
    mem_ctl.rd_en   = ((state == ST_SCAN) || (state == ST_APPLY)) && issuing;
    rd_addr         = AW'(idx);
    mem_ctl.wr_en   = (state == ST_CLEAR) || ((state == ST_APPLY) && pend);
    wr_addr         = (state == ST_CLEAR) ? clr_cnt : AW'(pend_idx);
    mem_ctl.wr_data = (state == ST_CLEAR) ? 8'h00 : new_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      issuing <= 1'b0;
      pend    <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          if (clr_cnt == CLR_LAST) begin
            state <= ST_IDLE;
          end else begin
            clr_cnt <= clr_cnt + 1'b1;
          end
        end
        ST_IDLE: begin
          if (item_take) begin
            kind     <= item.kind;
            start    <= start_in;
            count    <= item.run_length;
            down     <= item.search_down;
            eff      <= eff_in;
            scan_st  <= '0;
            ok       <= 1'b0;
            bv       <= 1'b0;
            used     <= '0;
            rs       <= '0;
            rsize    <= '0;
            apply_en <= 1'b0;
            set_bits <= 1'b0;
            lo       <= '0;
            hi_end   <= '0;
            pend     <= 1'b0;
            issuing  <= 1'b1;
            idx      <= '0;
            state    <= (eff_in == 8'd0) ? ST_DONE : ST_APPLY;
            priority if (item.kind == KIND_ALLOC) begin
              if (l_in != '0 && item.run_length != '0) begin
                if (item.search_down) begin
                  idx        <= dn_bound[10:3];
                  scan_bound <= dn_bound;
                  state      <= ST_SCAN;
                end else if (start_in < l_in) begin
                  idx        <= start_in[10:3];
                  scan_bound <= start_in;
                  state      <= ST_SCAN;
                end
              end
            end else if (item.kind == KIND_MARK_USED || item.kind == KIND_MARK_FREE) begin
              if (mark_end <= {1'b0, l_in}) begin
                ok       <= 1'b1;
                apply_en <= 1'b1;
                set_bits <= (item.kind == KIND_MARK_USED);
                lo       <= start_in;
                hi_end   <= mark_end;
              end
            end else if (item.kind == KIND_FILL_USED || item.kind == KIND_FILL_FREE) begin
              ok       <= 1'b1;
              apply_en <= 1'b1;
              set_bits <= (item.kind == KIND_FILL_USED);
              hi_end   <= {1'b0, l_in};
            end else if (item.kind == KIND_TEST) begin
              ok <= (start_in < l_in);
            end
          end
        end
        ST_SCAN: begin
          if (issuing) begin
            pend     <= 1'b1;
            pend_idx <= idx;
            if (idx == scan_last) begin
              issuing <= 1'b0;
            end else begin
              idx <= down ? idx - 8'd1 : idx + 8'd1;
            end
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            scan_st <= scan_st_new;
            if (scan_hit) begin
              ok       <= 1'b1;
              apply_en <= 1'b1;
              set_bits <= 1'b1;
              lo       <= scan_st_new.first;
              hi_end   <= {1'b0, scan_st_new.first} + {1'b0, count};
              rs       <= scan_st_new.first[9:0];
              rsize    <= count;
            end
            if (scan_hit || pend_idx == scan_last) begin
              state   <= ST_APPLY;
              idx     <= '0;
              issuing <= 1'b1;
              pend    <= 1'b0;
            end
          end
        end
        ST_APPLY: begin
          if (issuing) begin
            pend     <= 1'b1;
            pend_idx <= idx;
            if (idx == eff_m1) begin
              issuing <= 1'b0;
            end else begin
              idx <= idx + 8'd1;
            end
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            used <= used + {7'b0, pop};
            if (kind == KIND_TEST && ok && pend_idx == start[10:3]) begin
              bv <= rd_data[start[2:0]];
            end
            if (pend_idx == eff_m1) begin
              state <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy          = (state != ST_IDLE);
  assign res_valid     = (state == ST_DONE) && out_free;
  assign res.ok        = ok;
  assign res.run_start = rs;
  assign res.run_size  = rsize;
  assign res.bit_value = bv;
  assign res.used_count = used;

endmodule

### design/bitmap_run_allocator_top.sv
// Each item walks the E effective bytes of the map, E = min(bytes_in_use, MAP_BYTES),
//   in a read-modify-write pass; a scanning allocate first reads the bytes it scans.
// The read port gives one byte a cycle; a new item is taken only once the sequencer
//   has handed the last result to the output. With E = 0 an item skips the map.
// Reset (synchronous, active high): a clearing pass zeroes the map, one byte a cycle,
//   with in_stall high; bytes_in_use returns to 128 at once.
module bitmap_run_allocator_top #(
  parameter int MAP_BYTES = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  kind,
  input  logic [9:0]  start_bit,
  input  logic [10:0] run_length,
  input  logic        search_down,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        ok,
  output logic [9:0]  run_start,
  output logic [10:0] run_size,
  output logic        bit_value,
  output logic [10:0] used_count,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  import bra_pkg::*;

  localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;

  logic [7:0]    bytes_in_use;
  item_t         item;
  res_t          seq_res;
  res_t          out_res;
  logic          seq_busy;
  logic          seq_res_valid;
  logic          out_free;
  logic          item_take;
  mem_ctl_t      mem_ctl;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [7:0]    rd_data;

  // Byte-count register: user writes only while the block holds no item; not enforced.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_in_use <= CFG_RESET;
    end else if (cfg_we) begin
      bytes_in_use <= cfg_wdata;
    end
  end

  // Take a new item whenever the sequencer is idle, even while a result waits at the output.
  assign in_stall  = seq_busy;
  assign item_take = in_valid && !seq_busy;

  assign item.kind        = kind;
  assign item.start_bit   = start_bit;
  assign item.run_length  = run_length;
  assign item.search_down = search_down;

  // The output slot is free when empty or being drained this cycle.
  assign out_free = !out_valid || !out_stall;

  bra_seq #(
    .MAP_BYTES (MAP_BYTES),
    .AW        (AW)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .item_take    (item_take),
    .item         (item),
    .bytes_in_use (bytes_in_use),
    .out_free     (out_free),
    .busy         (seq_busy),
    .res_valid    (seq_res_valid),
    .res          (seq_res),
    .mem_ctl      (mem_ctl),
    .rd_addr      (rd_addr),
    .wr_addr      (wr_addr),
    .rd_data      (rd_data)
  );

  // Usage map: one byte a bit group, synchronous read, read-modify-write from the sequencer.
  bra_map_mem #(
    .DEPTH (MAP_BYTES),
    .AW    (AW)
  ) u_map (
    .clk     (clk),
    .rd_en   (mem_ctl.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (mem_ctl.wr_en),
    .wr_addr (wr_addr),
    .wr_data (mem_ctl.wr_data)
  );

  // Output register: load a finished item, drop it once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (seq_res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_res_valid) begin
      out_res <= seq_res;
    end
  end

  assign ok         = out_res.ok;
  assign run_start  = out_res.run_start;
  assign run_size   = out_res.run_size;
  assign bit_value  = out_res.bit_value;
  assign used_count = out_res.used_count;

  // A result never overwrites one that is still stalled.
  assert property (@(posedge clk) disable iff (rst)
    seq_res_valid |-> (!out_valid || !out_stall))
    else $error("result loaded over a stalled item");

  // An accepted item makes the block busy on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block not busy after taking an item");

  // The used count never exceeds the bits in use.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (used_count <= {bytes_in_use, 3'b000}))
    else $error("used count beyond valid bits");

endmodule

### test/tb_bitmap_run_allocator_top.sv
`timescale 1ns / 100ps

module tb_bitmap_run_allocator_top;
  import bra_pkg::*;

  // Kinds the block must ignore: no state change, ok low.
  localparam logic [2:0] KIND_SPARE_6 = 3'd6;
  localparam logic [2:0] KIND_SPARE_7 = 3'd7;

  localparam int UNITS          = 1024;  // map bits at the default map size
  localparam int CYCLE_LIMIT    = 2_000_000;
  localparam int HOLD_OFF_SPAN  = 1500;  // long receiver hold-off, in cycles
  localparam int TAIL_CYCLES    = 300;   // beyond the worst item latency

  // Shadow copy of the usage bitmap. It predicts the reply to each accepted
  // request and holds the replies still due from the block, oldest first.
  class bitmap_mirror;
    bit          unit_used [UNITS];
    logic [7:0]  bytes_in_use;
    res_t        due_replies [$];
    int          errors;

    function new();
      foreach (unit_used[i]) unit_used[i] = 1'b0;
      bytes_in_use = CFG_RESET;
      errors       = 0;
    endfunction

    function int valid_units();
      return (bytes_in_use > 8'd128 ? 128 : int'(bytes_in_use)) * 8;
    endfunction

    function void record_request(item_t it);
      res_t reply;
      int   lim, first_free, run, len, from, j;
      bit   found;
      lim   = valid_units();
      len   = int'(it.run_length);
      from  = int'(it.start_bit);
      reply = '0;
      found = 1'b0;
      run   = 0;
      first_free = 0;
      case (it.kind)
        KIND_ALLOC: begin
          if (lim != 0 && len != 0) begin
            if (it.search_down) begin
              // Scan down from the start (clamped to the top bit) to bit 0 inclusive.
              for (j = (from < lim) ? from : lim - 1; j >= 0 && !found; j--) begin
                if (unit_used[j]) run = 0;
                else begin
                  first_free = j;
                  run++;
                end
                found = (run == len);
              end
            end else begin
              for (j = from; j < lim && !found; j++) begin
                if (unit_used[j]) run = 0;
                else begin
                  if (run == 0) first_free = j;
                  run++;
                end
                found = (run == len);
              end
            end
            if (found) begin
              for (j = first_free; j < first_free + len; j++) unit_used[j] = 1'b1;
              reply.ok        = 1'b1;
              reply.run_start = 10'(first_free);
              reply.run_size  = 11'(len);
            end
          end
        end
        KIND_MARK_USED, KIND_MARK_FREE: begin
          if (from + len <= lim) begin
            for (j = from; j < from + len; j++) unit_used[j] = (it.kind == KIND_MARK_USED);
            reply.ok = 1'b1;
          end
        end
        KIND_FILL_USED, KIND_FILL_FREE: begin
          // Only the bytes in use are filled; anything above them keeps its contents.
          for (j = 0; j < lim; j++) unit_used[j] = (it.kind == KIND_FILL_USED);
          reply.ok = 1'b1;
        end
        KIND_TEST: begin
          if (from < lim) begin
            reply.ok        = 1'b1;
            reply.bit_value = unit_used[from];
          end
        end
        default: begin
        end
      endcase
      run = 0;
      for (j = 0; j < lim; j++) run += int'(unit_used[j]);
      reply.used_count = 11'(run);
      due_replies.push_back(reply);
    endfunction

    function void compare_field(string name, logic [10:0] want, logic [10:0] seen);
      if (seen !== want) begin
        errors++;
        $error("%s: expected %0d, got %0d", name, want, seen);
      end
    endfunction

    function void check_reply(res_t seen);
      res_t want;
      if (due_replies.size() == 0) begin
        errors++;
        $error("reply with no request outstanding");
        return;
      end
      want = due_replies.pop_front();
      compare_field("ok",         11'(want.ok),        11'(seen.ok));
      compare_field("run_start",  11'(want.run_start), 11'(seen.run_start));
      compare_field("run_size",   want.run_size,       seen.run_size);
      compare_field("bit_value",  11'(want.bit_value), 11'(seen.bit_value));
      compare_field("used_count", want.used_count,     seen.used_count);
    endfunction
  endclass

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic [2:0]  kind        = KIND_TEST;
  logic [9:0]  start_bit   = '0;
  logic [10:0] run_length  = '0;
  logic        search_down = 1'b0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic        ok;
  logic [9:0]  run_start;
  logic [10:0] run_size;
  logic        bit_value;
  logic [10:0] used_count;
  logic        cfg_we      = 1'b0;
  logic [7:0]  cfg_wdata   = '0;

  bitmap_mirror mirror = new();

  // Idling knobs, changed per phase; hold_req asks the receiver for one long hold-off.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;
  int cycle_count    = 0;

  bitmap_run_allocator_top u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .start_bit  (start_bit),
    .run_length (run_length),
    .search_down(search_down),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .ok         (ok),
    .run_start  (run_start),
    .run_size   (run_size),
    .bit_value  (bit_value),
    .used_count (used_count),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abandon the run if it hangs; the limit is many times the slowest correct run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_bitmap_run_allocator_top: FAIL");
      $finish;
    end
  end

  // Receiver stall. Values read just after the edge are the ones the edge saw.
  initial begin : stall_drive
    int span;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        // Hold off for a long stretch so the block backs up and stalls its input.
        span     = hold_req;
        hold_req = 0;
        out_stall <= 1'b1;
        repeat (span) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Check every reply taken at an edge.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      mirror.check_reply(res_t'({ok, run_start, run_size, bit_value, used_count}));
  end

  function automatic item_t request(input logic [2:0] k, input int from, input int len,
                                    input bit down);
    item_t it;
    it.kind        = k;
    it.start_bit   = 10'(from);
    it.run_length  = 11'(len);
    it.search_down = down;
    return it;
  endfunction

  // Offer one item, idling first at the phase's rate; return at the edge that takes it.
  // Valid stays high into the next call so back-to-back items need no gap.
  task automatic send_item(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= it.kind;
    start_bit   <= it.start_bit;
    run_length  <= it.run_length;
    search_down <= it.search_down;
    do @(posedge clk); while (in_stall);
    mirror.record_request(it);
  endtask

  // Drop valid and wait for every outstanding reply; every kind gives exactly
  // one reply, so the block is idle once the last one is taken.
  task automatic drain();
    in_valid <= 1'b0;
    while (mirror.due_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_bytes(input logic [7:0] bytes);
    cfg_we    <= 1'b1;
    cfg_wdata <= bytes;
    @(posedge clk);
    cfg_we <= 1'b0;
    mirror.bytes_in_use = bytes;
  endtask

  // One random phase. Most requests stay inside the valid bits with lengths
  // small enough that allocations keep succeeding; the rest roam freely.
  task automatic run_random(input int count, input logic [7:0] bytes, input int send_pct,
                            input int recv_pct, input bit pressure);
    item_t it;
    int    lim, cap, pick, span, n;
    drain();
    write_bytes(bytes);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    if (pressure) hold_req = HOLD_OFF_SPAN;
    lim = (bytes > 8'd128 ? 128 : int'(bytes)) * 8;
    cap = (lim >= 64) ? lim / 8 : 8;
    for (n = 0; n < count; n++) begin
      // Pause the sender once until the block has answered everything.
      if (pressure && n == count / 2) drain();
      pick = $urandom_range(99);
      if (pick < 40)      it.kind = KIND_ALLOC;
      else if (pick < 58) it.kind = KIND_MARK_FREE;
      else if (pick < 68) it.kind = KIND_MARK_USED;
      else if (pick < 83) it.kind = KIND_TEST;
      else if (pick < 86) it.kind = KIND_FILL_USED;
      else if (pick < 93) it.kind = KIND_FILL_FREE;
      else                it.kind = 3'($urandom_range(7));
      if (lim > 0 && $urandom_range(9) < 8) it.start_bit = 10'($urandom_range(lim - 1));
      else                                  it.start_bit = 10'($urandom_range(UNITS - 1));
      if (it.kind == KIND_MARK_USED || it.kind == KIND_MARK_FREE) begin
        span = lim - int'(it.start_bit);
        if (span > 0 && $urandom_range(9) < 8) begin
          if ($urandom_range(1) && span > cap) span = cap;
          it.run_length = 11'($urandom_range(span));
        end else begin
          it.run_length = 11'($urandom_range(UNITS));
        end
      end else begin
        pick = $urandom_range(9);
        if (pick == 0)      it.run_length = '0;
        else if (pick == 1) it.run_length = 11'($urandom_range(UNITS));
        else                it.run_length = 11'($urandom_range(cap, 1));
      end
      it.search_down = 1'($urandom_range(1));
      send_item(it);
    end
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: whole-map runs, both scan directions, bounds, fills and spare kinds.
    send_item(request(KIND_TEST,      0,    0,    1'b0));
    send_item(request(KIND_ALLOC,     0,    0,    1'b0));   // zero length fails
    send_item(request(KIND_ALLOC,     0,    1024, 1'b0));   // takes the whole map
    send_item(request(KIND_TEST,      1023, 0,    1'b0));
    send_item(request(KIND_ALLOC,     0,    1,    1'b0));   // nothing left
    send_item(request(KIND_MARK_FREE, 0,    1024, 1'b0));
    send_item(request(KIND_MARK_USED, 1023, 1,    1'b0));
    send_item(request(KIND_MARK_USED, 1000, 25,   1'b0));   // runs off the top
    send_item(request(KIND_MARK_FREE, 1023, 0,    1'b0));   // empty range succeeds
    send_item(request(KIND_ALLOC,     1023, 3,    1'b1));   // skips the used top bit
    send_item(request(KIND_ALLOC,     2,    3,    1'b1));   // run ends on bit 0
    send_item(request(KIND_ALLOC,     1023, 1,    1'b0));   // upward from a used top bit
    send_item(request(KIND_ALLOC,     500,  8,    1'b0));
    send_item(request(KIND_FILL_USED, 0,    0,    1'b0));
    send_item(request(KIND_TEST,      512,  0,    1'b0));
    send_item(request(KIND_FILL_FREE, 0,    0,    1'b0));
    send_item(request(KIND_SPARE_6,   5,    5,    1'b0));
    send_item(request(KIND_SPARE_7,   5,    5,    1'b1));
    send_item(request(KIND_MARK_USED, 40,   8,    1'b0));   // lies above the narrow map below
    drain();

    // Narrow map: downward start clamps to the top bit, tests past it fail,
    // and a fill leaves the bits above untouched.
    write_bytes(8'd4);
    send_item(request(KIND_ALLOC,     1023, 2,    1'b1));
    send_item(request(KIND_TEST,      32,   0,    1'b0));
    send_item(request(KIND_TEST,      31,   0,    1'b0));
    send_item(request(KIND_FILL_USED, 0,    0,    1'b0));
    drain();

    // No valid bits at all.
    write_bytes(8'd0);
    send_item(request(KIND_ALLOC,     0,    1,    1'b0));
    send_item(request(KIND_FILL_FREE, 0,    0,    1'b0));

    // Random phases: sizes from empty to full, every idling pattern.
    run_random(200, 8'd128, 0,  0,  1'b0);
    run_random(250, 8'd16,  59, 0,  1'b0);
    run_random(250, 8'd16,  0,  59, 1'b1);
    run_random(200, 8'd1,   25, 25, 1'b0);
    run_random(100, 8'd0,   0,  0,  1'b0);
    run_random(250, 8'd5,   25, 25, 1'b0);
    run_random(200, 8'd128, 25, 25, 1'b0);
    run_random(150, 8'd64,  59, 0,  1'b0);
    run_random(200, 8'd3,   0,  59, 1'b0);

    // Catch any stray reply arriving late.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mirror.errors == 0 && mirror.due_replies.size() == 0)
      $display("tb_bitmap_run_allocator_top: PASS");
    else
      $display("tb_bitmap_run_allocator_top: FAIL");
    $finish;
  end

endmodule
